// ===== hw/rtl/avapm_pkg.sv =====
// ----------------------------------------------------------------------------
// avapm_pkg
// shared types, constants and the segment lookup of the averaged panel meter
// ----------------------------------------------------------------------------
package avapm_pkg;

    parameter int unsigned WINDOW_DEF = 12;

    parameter logic [11:0] REF_MV_RESET = 12'd3300;
    parameter logic [12:0] MA_MAX       = 13'd8191;
    parameter logic [7:0]  SEG_DOT      = 8'h80;

    // current x reference x 100 / 192465 taken as a multiply by
    // ceil(2^40 * 100 / 192465) and a shift by 40, exact for 24-bit products
    parameter logic [29:0] MA_RECIP     = 30'd571278741;

    typedef struct packed {
        logic [11:0] voltage_sample;
        logic [11:0] current_sample;
    } t_in_item;

    typedef struct packed {
        logic [15:0] voltage_mv;
        logic [12:0] current_ma;
        logic [7:0]  seg_volt_tens;
        logic [7:0]  seg_volt_units;
        logic [7:0]  seg_volt_tenths;
        logic [7:0]  seg_volt_hundredths;
        logic [7:0]  seg_amp_units;
        logic [7:0]  seg_amp_tenths;
        logic [7:0]  seg_amp_hundredths;
        logic [7:0]  seg_amp_thousandths;
    } t_out_item;

    // gfedcba in bits 6..0, decimal point off
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== hw/rtl/averaged_volt_amp_panel_meter_top.sv =====
// ----------------------------------------------------------------------------
// averaged_volt_amp_panel_meter_top
// moving-average volt/amp meter with scaling and seven-segment digit encoding
// ----------------------------------------------------------------------------
// One item carries a raw voltage and a raw current sample and yields one result
// item: millivolts, milliamps and eight segment patterns. Items are handled one
// at a time; an accepted item passes the window update, the restoring divider
// for the average, which retires one quotient bit per cycle over the sum width,
// the compensation, the scaling multiplies and a 16-step double-dabble pass that
// converts both readings to decimal in parallel, and its result is then loaded
// into the output register once that register is free. The next item can be
// taken as soon as the result is loaded. The millivolt scaling divides by 4095
// with a shift-and-add reciprocal and the milliamp scaling uses a reciprocal
// multiply. The raw voltage samples sit in a small synchronous ring memory read
// at acceptance and written back in the following cycle, before the next item
// can be taken. The result register frees the input side: a new item may be
// accepted while the previous result still waits. The reference register may be
// written at any time the block is idle and is always ready.
// ----------------------------------------------------------------------------
module averaged_volt_amp_panel_meter_top #(
    parameter int unsigned WINDOW = avapm_pkg::WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // reference register write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [11:0]          i_cfg_data,
    // sample items
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  avapm_pkg::t_in_item  i_in_item,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output avapm_pkg::t_out_item o_out_item
);

    localparam int unsigned SLOT_W    = $clog2(WINDOW);
    localparam int unsigned FILL_W    = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W     = 12 + $clog2(WINDOW);
    localparam int unsigned DIV_W     = SUM_W;            // divider shift register
    localparam int unsigned DEN_W     = FILL_W;           // divisor up to the window
    localparam int unsigned BCD_STEPS = 16;
    localparam int unsigned CNT_W     = $clog2(BCD_STEPS + 1);
    localparam int unsigned VP_W      = 28;               // compensated volts x ref
    localparam int unsigned BCD_W     = 20;               // five decimal digits

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_AVG,
        S_COMP,
        S_MUL,
        S_MUL2,
        S_SCALE,
        S_BCD,
        S_OUT
    } t_state;

    // control state
    t_state              r_state;
    logic [11:0]         r_ref_mv;
    logic [SUM_W-1:0]    r_sum;
    logic [SLOT_W-1:0]   r_slot;
    logic [FILL_W-1:0]   r_fill;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_cnt;

    // payload
    logic [11:0]         r_v;
    logic [11:0]         r_c;
    logic [11:0]         r_ring_q;
    logic [11:0]         r_avg;
    logic [15:0]         r_comp;
    logic [VP_W-1:0]     r_vprod;
    logic [23:0]         r_cprod;
    logic [39:0]         r_mv_a;
    logic [32:0]         r_mv_b;
    logic [53:0]         r_ma_prod;
    logic [15:0]         r_mv;
    logic [12:0]         r_ma;
    logic [DIV_W-1:0]    r_q;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [15:0]         r_bin_v;
    logic [15:0]         r_bin_a;
    logic [BCD_W-1:0]    r_bcd_v;
    logic [15:0]         r_bcd_a;
    avapm_pkg::t_out_item r_out;

    // sample ring memory
    logic [11:0]         r_ring [WINDOW];

    // combinational helpers
    logic                win_full;
    logic [SUM_W-1:0]    n_sum;
    logic [DEN_W-1:0]    n_den;
    logic [DEN_W:0]      rem_sh;
    logic                fits;
    logic [DEN_W:0]      rem_diff;
    logic [DEN_W-1:0]    n_rem;
    logic [DIV_W-1:0]    n_q;
    logic [15:0]         avg_x10;
    logic [15:0]         n_comp;
    logic [39:0]         mv_sum;
    logic [15:0]         n_mv;
    logic [13:0]         ma_raw;
    logic [12:0]         n_ma;
    logic                in_acc;

    // one double-dabble step: adjust each digit, then shift in the next bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bin_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < BCD_W / 4; k++) begin
            if (adj[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = adj[k*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // window update: warm-up adds, full window swaps oldest for newest
    always_comb begin
        win_full = (r_fill == FILL_W'(WINDOW));
        if (win_full) begin
            n_sum = r_sum - SUM_W'(r_ring_q) + SUM_W'(r_v);
            n_den = DEN_W'(WINDOW);
        end else begin
            n_sum = r_sum + SUM_W'(r_v);
            n_den = DEN_W'(r_fill) + DEN_W'(1);
        end
    end

    // restoring divider step for the average, one quotient bit per cycle
    always_comb begin
        rem_sh   = {r_rem, r_q[DIV_W-1]};
        fits     = (rem_sh >= {1'b0, r_den});
        rem_diff = rem_sh - {1'b0, r_den};
        n_rem    = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        n_q      = {r_q[DIV_W-2:0], fits};
    end

    // current compensation, floored at zero; scaling; milliamp saturation
    always_comb begin
        avg_x10 = 16'(r_avg) * 16'd10;
        n_comp  = (avg_x10 > 16'(r_c)) ? (avg_x10 - 16'(r_c)) : 16'd0;
        // x / 4095 as x * (2^28 + 2^16 + 2^4 + 1) >> 40, exact below 2^28
        mv_sum  = r_mv_a + 40'(r_mv_b[32:16]);
        n_mv    = mv_sum[39:24];
        ma_raw  = r_ma_prod[53:40];
        n_ma    = (ma_raw > 14'(avapm_pkg::MA_MAX)) ? avapm_pkg::MA_MAX : ma_raw[12:0];
    end

    // ring: read at acceptance, written back in the update cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ring_q <= r_ring[r_slot];
        end
        if (r_state == S_UPDATE) begin
            r_ring[r_slot] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref_mv    <= avapm_pkg::REF_MV_RESET;
            r_sum       <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_ref_mv <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_v     <= i_in_item.voltage_sample;
                        r_c     <= i_in_item.current_sample;
                        r_state <= S_UPDATE;
                    end
                end

                S_UPDATE: begin
                    r_sum  <= n_sum;
                    r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
                    if (!win_full) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    // sum over fill count or window
                    r_q     <= n_sum;
                    r_rem   <= '0;
                    r_den   <= n_den;
                    r_cnt   <= CNT_W'(SUM_W);
                    r_state <= S_DIV_AVG;
                end

                S_DIV_AVG: begin
                    r_q   <= n_q;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_avg   <= n_q[11:0];
                        r_state <= S_COMP;
                    end
                end

                S_COMP: begin
                    r_comp  <= n_comp;
                    r_state <= S_MUL;
                end

                S_MUL: begin
                    r_vprod <= VP_W'(r_comp) * VP_W'(r_ref_mv);
                    r_cprod <= 24'(r_c) * 24'(r_ref_mv);
                    r_state <= S_MUL2;
                end

                S_MUL2: begin
                    // millivolt partials: product x 4097 and product x 17
                    r_mv_a    <= 40'({r_vprod, 12'd0}) + 40'(r_vprod);
                    r_mv_b    <= 33'({r_vprod, 4'd0}) + 33'(r_vprod);
                    r_ma_prod <= 54'(r_cprod) * 54'(avapm_pkg::MA_RECIP);
                    r_state   <= S_SCALE;
                end

                S_SCALE: begin
                    r_mv    <= n_mv;
                    r_ma    <= n_ma;
                    r_bin_v <= n_mv;
                    r_bin_a <= 16'(n_ma);
                    r_bcd_v <= '0;
                    r_bcd_a <= '0;
                    r_cnt   <= CNT_W'(BCD_STEPS);
                    r_state <= S_BCD;
                end

                S_BCD: begin
                    r_bcd_v <= dd_step(r_bcd_v, r_bin_v[15]);
                    r_bcd_a <= 16'(dd_step(BCD_W'(r_bcd_a), r_bin_a[15]));
                    r_bin_v <= {r_bin_v[14:0], 1'b0};
                    r_bin_a <= {r_bin_a[14:0], 1'b0};
                    r_cnt   <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    // wait for the result register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_out.voltage_mv          <= r_mv;
                        r_out.current_ma          <= r_ma;
                        r_out.seg_volt_tens       <= avapm_pkg::seg_code(r_bcd_v[19:16]);
                        r_out.seg_volt_units      <= avapm_pkg::seg_code(r_bcd_v[15:12])
                                                     | avapm_pkg::SEG_DOT;
                        r_out.seg_volt_tenths     <= avapm_pkg::seg_code(r_bcd_v[11:8]);
                        r_out.seg_volt_hundredths <= avapm_pkg::seg_code(r_bcd_v[7:4]);
                        r_out.seg_amp_units       <= avapm_pkg::seg_code(r_bcd_a[15:12])
                                                     | avapm_pkg::SEG_DOT;
                        r_out.seg_amp_tenths      <= avapm_pkg::seg_code(r_bcd_a[11:8]);
                        r_out.seg_amp_hundredths  <= avapm_pkg::seg_code(r_bcd_a[7:4]);
                        r_out.seg_amp_thousandths <= avapm_pkg::seg_code(r_bcd_a[3:0]);
                        r_out_valid               <= 1'b1;
                        r_state                   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // fill count saturates at the window and the write slot stays in range
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(WINDOW)) && (r_slot <= SLOT_W'(WINDOW - 1)))
        else $error("fill count or write slot out of range");

    // the divider never runs with a zero divisor
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_AVG) |-> (r_den != '0))
        else $error("divider running with zero divisor");

    // an accepted item blocks the input until its result is posted
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    // a pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

endmodule
